@@ rtl/qdec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the quadrature decoder.
// No dependencies; imported by qdec_regs, qdec_ctrl, qdec_dp and the top level.
package qdec_pkg;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CPN      = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;

    localparam logic [4:0] CPN_RESET      = 5'd4;
    localparam logic [7:0] INTERVAL_RESET = 8'd5;
    localparam logic [3:0] STEP_RESET     = 4'd1;

    // Motion codes
    localparam logic [1:0] MOTION_STOP = 2'd0;
    localparam logic [1:0] MOTION_CCW  = 2'd1;
    localparam logic [1:0] MOTION_CW   = 2'd2;

    localparam logic [2:0]         STILL_RELOAD = 3'd4;
    localparam logic [9:0]         DECAY_RELOAD = 10'd800;
    localparam logic signed [10:0] ACC_MAX      = 11'sd1023;

    localparam logic [9:0] THR_1 = 10'd40;
    localparam logic [9:0] THR_2 = 10'd90;
    localparam logic [9:0] THR_3 = 10'd150;
    localparam logic [9:0] THR_4 = 10'd250;
    localparam logic [6:0] ADD_1 = 7'd2;
    localparam logic [6:0] ADD_2 = 7'd4;
    localparam logic [6:0] ADD_3 = 7'd40;
    localparam logic [6:0] ADD_4 = 7'd80;

    typedef struct packed {
        logic [4:0] clicks_per_notch;
        logic [7:0] sample_interval_ms;
        logic [3:0] accel_step;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic fold;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic fold_done;
    } t_stat;

    function automatic logic [1:0] next_cw(input logic [1:0] q);
        logic [1:0] r;
        case (q)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] next_ccw(input logic [1:0] q);
        logic [1:0] r;
        case (q)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    // Sum of the threshold increments that an acceleration magnitude passes
    function automatic logic [6:0] extra_coef(input logic [9:0] mag);
        logic [6:0] c;
        c = 7'd0;
        if (mag > THR_1) c = c + ADD_1;
        if (mag > THR_2) c = c + ADD_2;
        if (mag > THR_3) c = c + ADD_3;
        if (mag > THR_4) c = c + ADD_4;
        return c;
    endfunction

endpackage

@@ rtl/qdec_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on qdec_pkg.
module qdec_regs
    import qdec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [CFG_AW-1:0] i_paddr,
    input  logic [CFG_DW-1:0] i_pwdata,
    output logic [CFG_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] idx;

    assign wr_en = i_psel && i_penable && i_pwrite;
    assign idx   = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clicks_per_notch   <= CPN_RESET;
            r_cfg.sample_interval_ms <= INTERVAL_RESET;
            r_cfg.accel_step         <= STEP_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_CPN:      r_cfg.clicks_per_notch   <= i_pwdata[4:0];
                REG_INTERVAL: r_cfg.sample_interval_ms <= i_pwdata[7:0];
                REG_STEP:     r_cfg.accel_step         <= i_pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CPN:      o_prdata = {27'd0, r_cfg.clicks_per_notch};
            REG_INTERVAL: o_prdata = {24'd0, r_cfg.sample_interval_ms};
            REG_STEP:     o_prdata = {28'd0, r_cfg.accel_step};
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/qdec_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences sample update, notch fold and result hand-off.
// Depends on qdec_pkg.
module qdec_ctrl
    import qdec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FOLD = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!i_stat.fold_done) begin
                    o_cmd.fold = 1'b1;
                end else if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) n_out_valid = 1'b0;
        if (o_cmd.commit) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/qdec_dp.sv @@
`timescale 1ns / 1ps
// Datapath: decoder state, acceleration, repeated-subtraction notch fold
// and the result register. Depends on qdec_pkg.
module qdec_dp
    import qdec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    input  logic               i_sw1_level,
    input  logic               i_sw2_level,
    output t_stat              o_stat,
    output logic signed [31:0] o_position,
    output logic signed [11:0] o_notch_delta,
    output logic signed [10:0] o_accel_level,
    output logic [1:0]         o_motion
);

    // Decoder state
    logic [1:0]         r_prev, n_prev;
    logic [2:0]         r_still, n_still;
    logic [1:0]         r_motion, n_motion;
    logic signed [5:0]  r_res;
    logic signed [10:0] r_accel, n_accel;
    logic [9:0]         r_timer, n_timer;
    logic signed [31:0] r_pos;

    // Fold working registers
    logic               r_neg;
    logic [10:0]        r_mag;
    logic [10:0]        r_quot;

    // Result register
    logic signed [31:0] r_out_pos;
    logic signed [11:0] r_out_delta;
    logic signed [10:0] r_out_accel;
    logic [1:0]         r_out_motion;

    logic [1:0]         quad;
    logic signed [11:0] ticks;
    logic [4:0]         cpn;
    logic signed [11:0] delta;

    assign quad = {i_sw1_level, i_sw2_level};
    assign cpn  = (i_cfg.clicks_per_notch == 5'd0) ? 5'd1 : i_cfg.clicks_per_notch;

    always_comb begin
        logic [2:0]         still_dec;
        logic [9:0]         timer_dec;
        logic [9:0]         acc_abs;
        logic [10:0]        extra;
        logic signed [11:0] step;
        n_prev    = r_prev;
        n_still   = r_still;
        n_motion  = r_motion;
        n_accel   = r_accel;
        n_timer   = r_timer;
        step      = 12'sd0;
        still_dec = 3'd0;
        timer_dec = 10'd0;
        acc_abs   = 10'd0;
        extra     = 11'd0;
        if (quad == r_prev) begin
            still_dec = (r_still != 3'd0) ? r_still - 3'd1 : 3'd0;
            n_still   = still_dec;
            if (still_dec == 3'd0) begin
                n_motion  = MOTION_STOP;
                timer_dec = (r_timer > {2'd0, i_cfg.sample_interval_ms})
                          ? r_timer - {2'd0, i_cfg.sample_interval_ms} : 10'd0;
                n_timer   = timer_dec;
                if (timer_dec == 10'd0) n_accel = 11'sd0;
            end
        end else begin
            n_still = STILL_RELOAD;
            n_timer = DECAY_RELOAD;
            n_prev  = quad;
            if (r_accel < 0) begin
                if (r_accel > -ACC_MAX) n_accel = r_accel - 11'sd1;
            end else begin
                if (r_accel < ACC_MAX) n_accel = r_accel + 11'sd1;
            end
            if (r_motion == MOTION_STOP) begin
                if (quad == next_cw(r_prev)) begin
                    n_motion = MOTION_CW;
                    step     = 12'sd1;
                end else if (quad == next_ccw(r_prev)) begin
                    n_motion = MOTION_CCW;
                    step     = -12'sd1;
                end
            end else if (r_motion == MOTION_CW) begin
                if (quad == next_cw(r_prev)) begin
                    if (n_accel <= 0) n_accel = 11'sd1;
                    acc_abs = n_accel[9:0];
                    extra   = {4'd0, extra_coef(acc_abs)} * {7'd0, i_cfg.accel_step};
                    step    = $signed({1'b0, extra}) + 12'sd1;
                end
            end else begin
                if (quad == next_ccw(r_prev)) begin
                    if (n_accel >= 0) n_accel = -11'sd1;
                    acc_abs = 10'(-n_accel);
                    extra   = {4'd0, extra_coef(acc_abs)} * {7'd0, i_cfg.accel_step};
                    step    = -($signed({1'b0, extra}) + 12'sd1);
                end
            end
        end
        ticks = {{6{r_res[5]}}, r_res} + step;
    end

    assign o_stat.fold_done = (r_mag < {6'd0, cpn});
    assign delta = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 2'd0;
            r_still  <= 3'd0;
            r_motion <= MOTION_STOP;
            r_res    <= 6'sd0;
            r_accel  <= 11'sd0;
            r_timer  <= 10'd0;
            r_pos    <= 32'sd0;
        end else begin
            if (i_cmd.start) begin
                r_prev   <= n_prev;
                r_still  <= n_still;
                r_motion <= n_motion;
                r_accel  <= n_accel;
                r_timer  <= n_timer;
            end
            if (i_cmd.commit) begin
                r_res <= r_neg ? -$signed({1'b0, r_mag[4:0]}) : $signed({1'b0, r_mag[4:0]});
                r_pos <= r_pos + {{20{delta[11]}}, delta};
            end
        end
    end

    // Fold magnitude toward zero, one subtraction per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_neg  <= ticks[11];
            r_mag  <= ticks[11] ? 11'(-ticks) : ticks[10:0];
            r_quot <= 11'd0;
        end else if (i_cmd.fold) begin
            r_mag  <= r_mag - {6'd0, cpn};
            r_quot <= r_quot + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_pos    <= r_pos + {{20{delta[11]}}, delta};
            r_out_delta  <= delta;
            r_out_accel  <= r_accel;
            r_out_motion <= r_motion;
        end
    end

    assign o_position    = r_out_pos;
    assign o_notch_delta = r_out_delta;
    assign o_accel_level = r_out_accel;
    assign o_motion      = r_out_motion;

endmodule

@@ rtl/quadrature_decoder_with_accel.sv @@
`timescale 1ns / 1ps
// Quadrature encoder decoder with acceleration: top level.
// Depends on qdec_pkg, qdec_regs, qdec_ctrl and qdec_dp.
//
// Each sample of the two switch levels yields one result: notch position,
// notches added, signed acceleration count and motion state. The fold unit
// divides |ticks| by clicks_per_notch, subtracting clicks_per_notch once per
// cycle; the quotient N = |ticks| / clicks_per_notch is up to about 1900 with
// clicks_per_notch 1, accel_step 15 and maximum acceleration. The result then
// enters the output register. The next sample is taken the cycle after the
// result enters the output register, so a new sample is not accepted while
// one is being folded; the output register holds a result until the sink
// takes it, and a folded sample waits for that slot. Write configuration only
// while idle.
module quadrature_decoder_with_accel
    import qdec_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB-style configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    // sample input
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [0] sw1_level, [1] sw2_level, rest zero
    // result output
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata   // [31:0] position, [43:32] notch_delta,
                                             // [54:44] accel_level, [56:55] motion
);

    t_cfg               cfg;
    t_cmd               cmd;
    t_stat              stat;
    logic signed [31:0] position;
    logic signed [11:0] notch_delta;
    logic signed [10:0] accel_level;
    logic [1:0]         motion;

    assign pready = 1'b1;

    qdec_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    qdec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    qdec_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_sw1_level   (s_axis_tdata[0]),
        .i_sw2_level   (s_axis_tdata[1]),
        .o_stat        (stat),
        .o_position    (position),
        .o_notch_delta (notch_delta),
        .o_accel_level (accel_level),
        .o_motion      (motion)
    );

    assign m_axis_tdata = {7'd0, motion, accel_level, notch_delta, position};

endmodule

@@ rtl/qdec_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the quadrature decoder, bound to the top level.
// Depends on quadrature_decoder_with_accel port names only.
module qdec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Motion code is stopped, ccw or cw
    a_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[56:55] != 2'd3)
        else $error("illegal motion code");

    // Acceleration count saturates short of the most negative code
    a_accel_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[54:44] != 11'h400)
        else $error("acceleration count out of range");

endmodule

bind quadrature_decoder_with_accel qdec_checker u_qdec_checker (.*);
